// File: design/hcbp_pkg.sv
package hcbp_pkg;

  // Command codes carried in the command field
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Input transaction: one command with its operands
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [31:0] code_value;
    logic [5:0]  code_length;
  } item_t;

  // Output transaction: one packed byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

endpackage

// File: design/huffman_code_table_bit_packer.sv
// Huffman code table and bit packer. A load command writes the code word and
// length for one symbol into a synchronous code table. An encode command reads
// the symbol's entry, appends its code bits (most significant first) to the
// pending partial byte, and sends every completed byte out, one byte per
// transaction. A flush command sends a non-empty partial byte padded with
// zeros and clears it. The last byte produced by an input transaction carries
// last = 1. Timing: a transaction is accepted every cycle as long as each one
// produces at most one byte and the result port does not stall. A transaction
// that produces more bytes holds the next one in stage 1 until the output
// buffer, which shifts out one byte per result transaction, has drained. A
// transaction passes through the stage 1 register and then the output buffer
// before its first byte is offered. Table entries are undefined until loaded,
// and a symbol must be loaded before it is encoded.
module huffman_code_table_bit_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW        = $clog2(SYMBOL_COUNT);
  localparam int LW        = $clog2(MAX_CODE_LEN + 1);
  localparam int WIN       = 8 + MAX_CODE_LEN;
  localparam int TW        = $clog2(WIN);
  localparam int CW        = TW - 3;
  localparam int BYTES_MAX = (7 + MAX_CODE_LEN) / 8;

  typedef struct packed {
    logic [MAX_CODE_LEN-1:0] code;
    logic [LW-1:0]           len;
  } entry_t;

  // Code table and its registered read port
  entry_t table_mem [SYMBOL_COUNT];
  entry_t rd_entry;

  // Stage 1: command waiting for the packer
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic       s1_in_range;

  // Packer state
  logic [7:0]     pend_byte;
  logic [2:0]     pend_cnt;
  logic [WIN-1:0] pack_buf;
  logic [CW-1:0]  buf_cnt;

  logic                    item_acc;
  logic                    result_acc;
  logic                    in_range;
  entry_t                  wr_entry;
  logic                    buf_free;
  logic                    s1_adv;
  logic [MAX_CODE_LEN-1:0] aligned;
  logic [WIN-1:0]          window;
  logic [TW-1:0]           total;
  logic [CW-1:0]           enc_bytes;
  logic [WIN-1:0]          shifted;
  logic [WIN-1:0]          buf_next;
  logic [CW-1:0]           buf_cnt_next;
  logic [7:0]              pend_byte_next;
  logic [2:0]              pend_cnt_next;

  assign item_acc   = item_valid && !item_stall;
  assign result_acc = result_valid && !result_stall;
  assign in_range   = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);

  // Saturate the length; high code bits drop out when the code is aligned
  always_comb begin
    wr_entry.code = item.code_value[MAX_CODE_LEN-1:0];
    if (item.code_length > 6'(MAX_CODE_LEN)) begin
      wr_entry.len = LW'(MAX_CODE_LEN);
    end else begin
      wr_entry.len = item.code_length[LW-1:0];
    end
  end

  // Write loads, read the entry of every accepted transaction
  always_ff @(posedge clk) begin
    if (item_acc && item.command == CMD_LOAD && in_range) begin
      table_mem[item.symbol[AW-1:0]] <= wr_entry;
    end
    if (item_acc) begin
      rd_entry    <= table_mem[item.symbol[AW-1:0]];
      s1_cmd      <= item.command;
      s1_in_range <= in_range;
    end
  end

  // Advance stage 1 once the output buffer drains
  assign buf_free   = (buf_cnt == '0) || (buf_cnt == CW'(1) && !result_stall);
  assign s1_adv     = s1_valid && buf_free;
  assign item_stall = s1_valid && !buf_free;

  // Build the packing window: pending bits on top, then the code bits
  always_comb begin
    aligned   = rd_entry.code << ((LW+1)'(MAX_CODE_LEN) - {1'b0, rd_entry.len});
    window    = {pend_byte, {MAX_CODE_LEN{1'b0}}} | ({aligned, 8'h00} >> pend_cnt);
    total     = TW'(pend_cnt) + TW'(rd_entry.len);
    enc_bytes = total[TW-1:3];
    shifted   = window << {enc_bytes, 3'b000};
  end

  // Decide what stage 1 hands to the output buffer and the pending byte
  always_comb begin
    buf_next       = window;
    buf_cnt_next   = '0;
    pend_byte_next = pend_byte;
    pend_cnt_next  = pend_cnt;
    case (s1_cmd)
      CMD_ENCODE: begin
        if (s1_in_range) begin
          buf_cnt_next   = enc_bytes;
          pend_byte_next = shifted[WIN-1 -: 8];
          pend_cnt_next  = total[2:0];
        end
      end
      CMD_FLUSH: begin
        buf_next       = {pend_byte, {MAX_CODE_LEN{1'b0}}};
        buf_cnt_next   = CW'(pend_cnt != 3'd0);
        pend_byte_next = 8'h00;
        pend_cnt_next  = 3'd0;
      end
      default: begin
        buf_cnt_next = '0;
      end
    endcase
  end

  // Control and packer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pend_byte <= 8'h00;
      pend_cnt  <= 3'd0;
      buf_cnt   <= '0;
    end else begin
      if (item_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        pend_byte <= pend_byte_next;
        pend_cnt  <= pend_cnt_next;
        buf_cnt   <= buf_cnt_next;
      end else if (result_acc) begin
        buf_cnt <= buf_cnt - CW'(1);
      end
    end
  end

  // Output buffer: load from stage 1, shift one byte per transaction
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pack_buf <= buf_next;
    end else if (result_acc) begin
      pack_buf <= pack_buf << 8;
    end
  end

  assign result_valid    = buf_cnt != '0;
  assign result.out_byte = pack_buf[WIN-1 -: 8];
  assign result.last     = buf_cnt == CW'(1);

`ifndef NO_ASSERTIONS
  // Input stalls only while stage 1 holds a command
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("input stalled with stage 1 empty");

  // Output buffer never holds more bytes than one code can fill
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= CW'(BYTES_MAX))
    else $error("output buffer count out of range");

  // A flush leaves no pending bits behind
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_cmd == CMD_FLUSH) |=> (pend_cnt == 3'd0 && pend_byte == 8'h00))
    else $error("pending byte not cleared by flush");
`endif

endmodule
